### sv/hvn_pkg.sv
// Shared types and constants of the heightmap vertex normal block.
`default_nettype none

package hvn_pkg;

    localparam int unsigned SCALE_W   = 16;
    localparam int unsigned MAP_W     = 13;
    localparam int unsigned CODE_W    = 8;
    localparam int unsigned POS_W     = 28;
    localparam int unsigned Q14_W     = 16;
    localparam int unsigned TEX_W     = 16;
    localparam int unsigned CFG_IDX_W = 8;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SCALE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_GAIN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT  = 8'd3;

    localparam logic [SCALE_W-1:0] RST_GRID_SCALE  = 16'd256;
    localparam logic [SCALE_W-1:0] RST_HEIGHT_GAIN = 16'd256;
    localparam logic [MAP_W-1:0]   RST_MAP_SIZE    = 13'd4096;

    // Height scaling: (code * gain + 127) / 255 by reciprocal multiplication.
    localparam int unsigned PYX_W    = 24;
    localparam int unsigned PYR_W    = 25;
    localparam int unsigned PY_SHIFT = 32;
    localparam logic [PYR_W-1:0]  PY_RECIP = 25'd16843009;
    localparam logic [PYX_W-1:0]  PY_DIV   = 24'd255;
    localparam logic [PYX_W-1:0]  PY_RND   = 24'd127;

    localparam int unsigned TEX_DIV = 30;
    localparam int unsigned TEX_RND = 15;

    // Normal vector arithmetic.
    localparam int unsigned VMAG_W  = 25;
    localparam int unsigned SQ_W    = 50;
    localparam int unsigned SUM_W   = 52;
    localparam int unsigned ROOT_W  = 26;
    localparam int unsigned NUM_W   = 40;
    localparam int unsigned DQ_W    = 15;
    localparam int unsigned DCNT_W  = 4;
    localparam int unsigned FRAC_SH = 14;
    localparam logic [VMAG_W-1:0] VY_FACTOR = 25'd510;
    localparam logic [Q14_W-1:0]  UNIT_Q14  = 16'd16384;

    typedef enum logic [1:0] {
        COMP_X = 2'd0,
        COMP_Y = 2'd1,
        COMP_Z = 2'd2
    } t_comp;

    typedef struct packed {
        logic  load;
        logic  mul;
        logic  sq;
        logic  sum;
        logic  sq_init;
        logic  sq_step;
        logic  div_init;
        logic  div_step;
        logic  div_store;
        logic  out_load;
        t_comp comp;
    } t_cmd;

    typedef struct packed {
        logic sq_last;
        logic div_last;
    } t_sts;

endpackage

`default_nettype wire

### sv/hvn_ctrl.sv
// Sequencer that steps one vertex through the datapath.
`default_nettype none

module hvn_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  wire logic          i_stall,
    output hvn_pkg::t_cmd      o_cmd,
    input  wire hvn_pkg::t_sts i_sts
);
    import hvn_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_MUL     = 10'b0000000010,
        ST_SQ      = 10'b0000000100,
        ST_SUM     = 10'b0000001000,
        ST_SQINIT  = 10'b0000010000,
        ST_SQSTEP  = 10'b0000100000,
        ST_DINIT   = 10'b0001000000,
        ST_DSTEP   = 10'b0010000000,
        ST_DSTORE  = 10'b0100000000,
        ST_OUT     = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    t_comp  r_comp, n_comp;
    logic   r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_comp  = r_comp;
        n_valid = r_valid & i_stall;
        o_cmd   = '0;
        o_cmd.comp = r_comp;
        case (r_state)
            ST_IDLE: begin
                n_comp = COMP_X;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_SQ;
            end
            ST_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_SQINIT;
            end
            ST_SQINIT: begin
                o_cmd.sq_init = 1'b1;
                n_state       = ST_SQSTEP;
            end
            ST_SQSTEP: begin
                o_cmd.sq_step = 1'b1;
                if (i_sts.sq_last) begin
                    n_state = ST_DINIT;
                end
            end
            ST_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = ST_DSTEP;
            end
            ST_DSTEP: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_DSTORE;
                end
            end
            ST_DSTORE: begin
                o_cmd.div_store = 1'b1;
                case (r_comp)
                    COMP_X: begin
                        n_comp  = COMP_Y;
                        n_state = ST_DINIT;
                    end
                    COMP_Y: begin
                        n_comp  = COMP_Z;
                        n_state = ST_DINIT;
                    end
                    default: begin
                        n_comp  = COMP_X;
                        n_state = ST_OUT;
                    end
                endcase
            end
            ST_OUT: begin
                if (!r_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_comp  <= COMP_X;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_comp  <= n_comp;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

### sv/hvn_dp.sv
// Datapath: configuration, products, square root, shared divider and result registers.
`default_nettype none

module hvn_dp #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire hvn_pkg::t_cmd                         i_cmd,
    output hvn_pkg::t_sts                              o_sts,
    input  wire logic                                  i_cfg_wr,
    input  wire logic [hvn_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [hvn_pkg::SCALE_W-1:0]           i_cfg_data,
    input  wire logic [COORD_BITS-1:0]                 i_col,
    input  wire logic [COORD_BITS-1:0]                 i_row,
    input  wire logic [hvn_pkg::CODE_W-1:0]            i_h_mid,
    input  wire logic [hvn_pkg::CODE_W-1:0]            i_h_next_row,
    input  wire logic [hvn_pkg::CODE_W-1:0]            i_h_prev_row,
    input  wire logic [hvn_pkg::CODE_W-1:0]            i_h_next_col,
    input  wire logic [hvn_pkg::CODE_W-1:0]            i_h_prev_col,
    input  wire logic                                  i_restart_bounds,
    output logic [hvn_pkg::POS_W-1:0]                  o_pos_x,
    output logic [hvn_pkg::SCALE_W-1:0]                o_pos_y,
    output logic [hvn_pkg::POS_W-1:0]                  o_pos_z,
    output logic signed [hvn_pkg::Q14_W-1:0]           o_norm_x,
    output logic signed [hvn_pkg::Q14_W-1:0]           o_norm_y,
    output logic signed [hvn_pkg::Q14_W-1:0]           o_norm_z,
    output logic [hvn_pkg::TEX_W-1:0]                  o_tex_u,
    output logic [hvn_pkg::TEX_W-1:0]                  o_tex_v,
    output logic [hvn_pkg::SCALE_W-1:0]                o_bound_low,
    output logic [hvn_pkg::SCALE_W-1:0]                o_bound_high
);
    import hvn_pkg::*;

    localparam int CW      = COORD_BITS;
    localparam int EW      = (CW + 1 > MAP_W) ? CW + 1 : MAP_W;
    localparam int TX_W    = CW + 8;
    localparam int TEX_SH  = CW + 13;
    localparam int TM_W    = TEX_SH - 4;
    localparam int TP_W    = TX_W + TM_W;
    localparam int TQ_W    = CW + 4;
    localparam int PP_W    = PYX_W + PYR_W;
    localparam logic [63:0] TEX_RECIP = (64'd1 << TEX_SH) / TEX_DIV;

    // Configuration registers.
    logic [SCALE_W-1:0] r_grid_scale, r_height_gain;
    logic [MAP_W-1:0]   r_map_width, r_map_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_scale  <= RST_GRID_SCALE;
            r_height_gain <= RST_HEIGHT_GAIN;
            r_map_width   <= RST_MAP_SIZE;
            r_map_height  <= RST_MAP_SIZE;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_GRID_SCALE:  r_grid_scale  <= i_cfg_data;
                CFG_HEIGHT_GAIN: r_height_gain <= i_cfg_data;
                CFG_MAP_WIDTH:   r_map_width   <= i_cfg_data[MAP_W-1:0];
                CFG_MAP_HEIGHT:  r_map_height  <= i_cfg_data[MAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Neighbour selection with the map edge fallback.
    logic w_a_ok, w_b_ok, w_c_ok, w_d_ok;
    assign w_a_ok = (EW'(i_row) + EW'(1)) < EW'(r_map_height);
    assign w_b_ok = (i_row != '0) && ((EW'(i_row) - EW'(1)) < EW'(r_map_height));
    assign w_c_ok = (EW'(i_col) + EW'(1)) < EW'(r_map_width);
    assign w_d_ok = (i_col != '0) && ((EW'(i_col) - EW'(1)) < EW'(r_map_width));

    logic [CW-1:0]     r_col, r_row;
    logic [CODE_W-1:0] r_mid, r_a, r_b, r_c, r_d;
    logic              r_restart;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col     <= i_col;
            r_row     <= i_row;
            r_mid     <= i_h_mid;
            r_a       <= w_a_ok ? i_h_next_row : i_h_mid;
            r_b       <= w_b_ok ? i_h_prev_row : i_h_mid;
            r_c       <= w_c_ok ? i_h_next_col : i_h_mid;
            r_d       <= w_d_ok ? i_h_prev_col : i_h_mid;
            r_restart <= i_restart_bounds;
        end
    end

    // First products.
    logic [CODE_W-1:0]     w_dx, w_dz;
    assign w_dx = (r_c > r_d) ? (r_c - r_d) : (r_d - r_c);
    assign w_dz = (r_a > r_b) ? (r_a - r_b) : (r_b - r_a);

    logic [POS_W-1:0]  r_posx, r_posz;
    logic [VMAG_W-1:0] r_vxm, r_vym, r_vzm;
    logic              r_xneg, r_zneg;
    logic [PYX_W-1:0]  r_pyx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_posx <= POS_W'((CW + SCALE_W)'(r_col) * (CW + SCALE_W)'(r_grid_scale));
            r_posz <= POS_W'((CW + SCALE_W)'(r_row) * (CW + SCALE_W)'(r_grid_scale));
            r_vxm  <= VMAG_W'(w_dx) * VMAG_W'(r_height_gain);
            r_vzm  <= VMAG_W'(w_dz) * VMAG_W'(r_height_gain);
            r_vym  <= VY_FACTOR * VMAG_W'(r_grid_scale);
            r_xneg <= r_c > r_d;
            r_zneg <= r_a > r_b;
            r_pyx  <= PYX_W'(r_mid) * PYX_W'(r_height_gain) + PY_RND;
        end
    end

    // Squares and reciprocal quotient estimates.
    logic [TX_W-1:0] w_tux, w_tvx;
    assign w_tux = {r_col, 8'h00} + TX_W'(TEX_RND);
    assign w_tvx = {r_row, 8'h00} + TX_W'(TEX_RND);

    logic [TP_W-1:0] w_tup, w_tvp;
    logic [PP_W-1:0] w_pyp;
    assign w_tup = TP_W'(w_tux) * TP_W'(TEX_RECIP);
    assign w_tvp = TP_W'(w_tvx) * TP_W'(TEX_RECIP);
    assign w_pyp = PP_W'(r_pyx) * PP_W'(PY_RECIP);

    logic [SQ_W-1:0]    r_sx, r_sy, r_sz;
    logic [TQ_W-1:0]    r_tuq, r_tvq;
    logic [SCALE_W-1:0] r_pyq;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq) begin
            r_sx  <= SQ_W'(r_vxm) * SQ_W'(r_vxm);
            r_sy  <= SQ_W'(r_vym) * SQ_W'(r_vym);
            r_sz  <= SQ_W'(r_vzm) * SQ_W'(r_vzm);
            r_tuq <= w_tup[TEX_SH +: TQ_W];
            r_tvq <= w_tvp[TEX_SH +: TQ_W];
            r_pyq <= w_pyp[PY_SHIFT +: SCALE_W];
        end
    end

    // Sum of squares and the one-step quotient corrections.
    logic [TX_W-1:0]  w_tur, w_tvr;
    logic [PYX_W-1:0] w_pyr;
    assign w_tur = w_tux - TX_W'(TX_W'(r_tuq) * TX_W'(TEX_DIV));
    assign w_tvr = w_tvx - TX_W'(TX_W'(r_tvq) * TX_W'(TEX_DIV));
    assign w_pyr = r_pyx - PYX_W'(PYX_W'(r_pyq) * PY_DIV);

    logic [SUM_W-1:0]   r_sum;
    logic               r_zero;
    logic [TEX_W-1:0]   r_tu, r_tv;
    logic [SCALE_W-1:0] r_py;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_sum  <= SUM_W'(r_sx) + SUM_W'(r_sy) + SUM_W'(r_sz);
            r_zero <= (r_sx == '0) && (r_sy == '0) && (r_sz == '0);
            r_tu   <= TEX_W'(r_tuq + TQ_W'(w_tur >= TX_W'(TEX_DIV)));
            r_tv   <= TEX_W'(r_tvq + TQ_W'(w_tvr >= TX_W'(TEX_DIV)));
            r_py   <= r_pyq + SCALE_W'(w_pyr >= PY_DIV);
        end
    end

    // Running bounds, updated once per vertex.
    logic [SCALE_W-1:0] r_run_min, r_run_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_min <= '1;
            r_run_max <= '0;
        end else if (i_cmd.sq_init) begin
            if (r_restart) begin
                r_run_min <= r_py;
                r_run_max <= r_py;
            end else begin
                if (r_py < r_run_min) begin
                    r_run_min <= r_py;
                end
                if (r_py > r_run_max) begin
                    r_run_max <= r_py;
                end
            end
        end
    end

    // Integer square root, two bits of the radicand per step.
    logic [SUM_W-1:0] r_rem, r_root, r_bit;
    logic [SUM_W:0]   w_trial;
    logic             w_sq_ge;
    assign w_trial = {1'b0, r_root} + {1'b0, r_bit};
    assign w_sq_ge = {1'b0, r_rem} >= w_trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_init) begin
            r_rem  <= r_sum;
            r_root <= '0;
            r_bit  <= SUM_W'(1) << (SUM_W - 2);
        end else if (i_cmd.sq_step) begin
            if (w_sq_ge) begin
                r_rem  <= r_rem - w_trial[SUM_W-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // Shared restoring divider for the three normal components.
    logic [ROOT_W-1:0] w_len;
    assign w_len = r_root[ROOT_W-1:0];

    logic [VMAG_W-1:0] w_mag;
    logic              w_neg;
    always_comb begin
        case (i_cmd.comp)
            COMP_X: begin
                w_mag = r_vxm;
                w_neg = r_xneg;
            end
            COMP_Y: begin
                w_mag = r_vym;
                w_neg = 1'b0;
            end
            default: begin
                w_mag = r_vzm;
                w_neg = r_zneg;
            end
        endcase
    end

    logic [NUM_W-1:0]  r_nrem, r_dvs;
    logic [DQ_W-1:0]   r_q;
    logic [DCNT_W-1:0] r_dcnt;
    logic              w_div_ge;
    assign w_div_ge = r_nrem >= r_dvs;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_nrem <= (NUM_W'(w_mag) << FRAC_SH) + NUM_W'(w_len >> 1);
            r_dvs  <= NUM_W'(w_len) << FRAC_SH;
            r_q    <= '0;
            r_dcnt <= DCNT_W'(DQ_W - 1);
        end else if (i_cmd.div_step) begin
            if (w_div_ge) begin
                r_nrem <= r_nrem - r_dvs;
            end
            r_q    <= {r_q[DQ_W-2:0], w_div_ge};
            r_dvs  <= r_dvs >> 1;
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
    end

    logic [Q14_W-1:0] w_qext, w_nval;
    assign w_qext = Q14_W'(r_q);
    assign w_nval = w_neg ? (~w_qext + Q14_W'(1)) : w_qext;

    logic signed [Q14_W-1:0] r_nx, r_ny, r_nz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            case (i_cmd.comp)
                COMP_X:  r_nx <= r_zero ? '0 : w_nval;
                COMP_Y:  r_ny <= r_zero ? UNIT_Q14 : w_nval;
                default: r_nz <= r_zero ? '0 : w_nval;
            endcase
        end
    end

    // Result register, loaded once the previous transaction has left.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_pos_x      <= r_posx;
            o_pos_y      <= r_py;
            o_pos_z      <= r_posz;
            o_norm_x     <= r_nx;
            o_norm_y     <= r_ny;
            o_norm_z     <= r_nz;
            o_tex_u      <= r_tu;
            o_tex_v      <= r_tv;
            o_bound_low  <= r_run_min;
            o_bound_high <= r_run_max;
        end
    end

    assign o_sts.sq_last  = r_bit[0];
    assign o_sts.div_last = (r_dcnt == '0);

endmodule

`default_nettype wire

### sv/heightmap_vertex_normal.sv
// The sequencer takes a new vertex only once the previous one has been handed to
// the output register; its run is set by the 26-step square root and
// the shared divider that serves each of the three normal components in turn.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle, drops o_valid,
// restores the register defaults and restarts the running bounds.
`default_nettype none

module heightmap_vertex_normal #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Configuration write channel; always ready.
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [hvn_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [hvn_pkg::SCALE_W-1:0]           i_cfg_data,
    // Vertex input channel.
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [COORD_BITS-1:0]                 i_col,
    input  wire logic [COORD_BITS-1:0]                 i_row,
    input  wire logic [hvn_pkg::CODE_W-1:0]            i_h_mid,
    input  wire logic [hvn_pkg::CODE_W-1:0]            i_h_next_row,
    input  wire logic [hvn_pkg::CODE_W-1:0]            i_h_prev_row,
    input  wire logic [hvn_pkg::CODE_W-1:0]            i_h_next_col,
    input  wire logic [hvn_pkg::CODE_W-1:0]            i_h_prev_col,
    input  wire logic                                  i_restart_bounds,
    // Vertex result channel.
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic [hvn_pkg::POS_W-1:0]                  o_pos_x,
    output logic [hvn_pkg::SCALE_W-1:0]                o_pos_y,
    output logic [hvn_pkg::POS_W-1:0]                  o_pos_z,
    output logic signed [hvn_pkg::Q14_W-1:0]           o_norm_x,
    output logic signed [hvn_pkg::Q14_W-1:0]           o_norm_y,
    output logic signed [hvn_pkg::Q14_W-1:0]           o_norm_z,
    output logic [hvn_pkg::TEX_W-1:0]                  o_tex_u,
    output logic [hvn_pkg::TEX_W-1:0]                  o_tex_v,
    output logic [hvn_pkg::SCALE_W-1:0]                o_bound_low,
    output logic [hvn_pkg::SCALE_W-1:0]                o_bound_high
);
    import hvn_pkg::*;

    // Commands from the sequencer and the loop-end status back to it.
    t_cmd w_cmd;
    t_sts w_sts;

    // Registers may be written at any time; the user keeps writes to idle periods,
    // so the port never has to hold a transaction off.
    assign o_cfg_ready = 1'b1;

    // The sequencer accepts a vertex only while idle. A finished result waits in
    // the datapath's output register, so the next vertex can be taken in while the
    // previous transaction is still stalled downstream.
    hvn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    // The datapath forms the positions by direct products, and the texture coordinates
    // and scaled height by reciprocal multiplication, then normalises the central-difference
    // cross product with an iterative square root and one shared bit-serial divider.
    hvn_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_wr         (i_cfg_valid & o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_col            (i_col),
        .i_row            (i_row),
        .i_h_mid          (i_h_mid),
        .i_h_next_row     (i_h_next_row),
        .i_h_prev_row     (i_h_prev_row),
        .i_h_next_col     (i_h_next_col),
        .i_h_prev_col     (i_h_prev_col),
        .i_restart_bounds (i_restart_bounds),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_pos_z          (o_pos_z),
        .o_norm_x         (o_norm_x),
        .o_norm_y         (o_norm_y),
        .o_norm_z         (o_norm_z),
        .o_tex_u          (o_tex_u),
        .o_tex_v          (o_tex_v),
        .o_bound_low      (o_bound_low),
        .o_bound_high     (o_bound_high)
    );

endmodule

`default_nettype wire

### sv/hvn_chk.sv
// Port-level checker for the heightmap vertex normal block, with its bind.
`default_nettype none

module hvn_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [15:0] o_pos_y,
    input wire logic [15:0] o_norm_y,
    input wire logic [15:0] o_bound_low,
    input wire logic [15:0] o_bound_high
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_valid && i_stall |=> o_valid)
        else $error("result transaction dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_valid && !o_stall |=> o_stall)
        else $error("input not held off after an accepted transaction");

    a_norm_y_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_norm_y[15])
        else $error("normal y component negative");

    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bound_low <= o_pos_y) && (o_pos_y <= o_bound_high))
        else $error("height outside its running bounds");

endmodule

bind heightmap_vertex_normal hvn_chk u_hvn_chk (.*);

`default_nettype wire
